// File: rtl/ckes_pkg.sv
// Shared types, constants and fixed-point helpers for the car Euler step block.
// Depends on nothing; the top, CORDIC and divider files import it.
`default_nettype none
package ckes_pkg;

	typedef logic signed [31:0] q16_t;

	localparam int CORDIC_ITERATIONS = 16;
	localparam int CORDIC_LAT = CORDIC_ITERATIONS + 3;
	localparam int CW = 34;
	localparam int GAIN_IDX = (CORDIC_ITERATIONS - 8 > 8) ? 8 : CORDIC_ITERATIONS - 8;

	localparam int DIV_BITS = 32;
	localparam int DIV_LAT = DIV_BITS + 3;

	localparam int ST_CIN = 3;
	localparam int ST_COUT = ST_CIN + CORDIC_LAT;
	localparam int ST_CS = ST_COUT + 1;
	localparam int ST_H = ST_COUT + 2;
	localparam int ST_HV = ST_COUT + 3;
	localparam int ST_XY = ST_COUT + 4;
	localparam int ST_TN = ST_COUT + DIV_LAT;
	localparam int ST_HTN = ST_TN + 1;
	localparam int ST_TQ = ST_CS + DIV_LAT;
	localparam int ST_JHS = ST_HTN + DIV_LAT;
	localparam int ST_FIN = ST_JHS + 2;

	localparam q16_t Q16_MAX = 32'sh7fffffff;
	localparam q16_t Q16_MIN = 32'sh80000000;
	localparam q16_t DRIVE_LIMIT = 32'sd65536000;
	localparam q16_t STEER_LIMIT = 32'sd411775;
	localparam logic signed [63:0] INV_TWO_PI_Q32 = 64'sd683565276;
	localparam logic signed [63:0] TWO_PI_Q29 = 64'sd3373259426;

	localparam logic [29:0] ATAN_Q30 [32] = '{
		30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
		30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
		30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
		30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
		30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
	};

	localparam logic [29:0] GAIN_Q30 [9] = '{
		30'd652039507, 30'd652034532, 30'd652033289, 30'd652032978, 30'd652032900,
		30'd652032880, 30'd652032876, 30'd652032874, 30'd652032874
	};

	localparam int CFG_IW = 3;
	localparam logic [CFG_IW-1:0] REG_WHEELBASE = 3'd0;
	localparam logic [CFG_IW-1:0] REG_STEP_SIZE = 3'd1;
	localparam logic [CFG_IW-1:0] REG_DRIVE_GAIN = 3'd2;
	localparam logic [CFG_IW-1:0] REG_DRIVE_OFFSET = 3'd3;
	localparam logic [CFG_IW-1:0] REG_STEER_GAIN = 3'd4;
	localparam logic [CFG_IW-1:0] REG_STEER_OFFSET = 3'd5;
	localparam logic [CFG_IW-1:0] REG_TORQUE_GAIN = 3'd6;

	function automatic q16_t sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return Q16_MAX;
		else if (v < -64'sd2147483648)
			return Q16_MIN;
		else
			return v[31:0];
	endfunction

	function automatic q16_t fmul(input q16_t a, input q16_t b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		p = p + 64'sd32768;
		return sat32(p >>> 16);
	endfunction

	function automatic q16_t fadd(input q16_t a, input q16_t b);
		return sat32(64'(a) + 64'(b));
	endfunction

	function automatic q16_t fsub(input q16_t a, input q16_t b);
		return sat32(64'(a) - 64'(b));
	endfunction

	function automatic q16_t clamp(input q16_t v, input q16_t lim);
		if (v > lim)
			return lim;
		else if (v < -lim)
			return -lim;
		else
			return v;
	endfunction

	function automatic q16_t q30_to_q16(input q16_t v);
		logic signed [32:0] t;
		t = 33'(v) + 33'sd8192;
		return 32'(t >>> 14);
	endfunction

endpackage
`default_nettype wire

// File: rtl/ckes_if.sv
// Item channels of the car Euler step block: one input item, one result item.
// Depends on nothing; valid/ready handshake with the fields alongside.
`default_nettype none
interface ckes_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] heading;
	logic signed [31:0] speed;
	logic signed [31:0] drive_cmd;
	logic signed [31:0] steer_cmd;

	modport source (output valid, pos_x, pos_y, heading, speed, drive_cmd, steer_cmd,
		input ready);
	modport sink (input valid, pos_x, pos_y, heading, speed, drive_cmd, steer_cmd,
		output ready);
endinterface

interface ckes_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] next_x;
	logic signed [31:0] next_y;
	logic signed [31:0] next_heading;
	logic signed [31:0] next_speed;
	logic signed [31:0] jac_x_heading;
	logic signed [31:0] jac_x_speed;
	logic signed [31:0] jac_y_heading;
	logic signed [31:0] jac_y_speed;
	logic signed [31:0] jac_heading_speed;
	logic signed [31:0] jac_heading_steer;
	logic signed [31:0] jac_speed_drive;

	modport source (output valid, next_x, next_y, next_heading, next_speed,
		jac_x_heading, jac_x_speed, jac_y_heading, jac_y_speed,
		jac_heading_speed, jac_heading_steer, jac_speed_drive, input ready);
	modport sink (input valid, next_x, next_y, next_heading, next_speed,
		jac_x_heading, jac_x_speed, jac_y_heading, jac_y_speed,
		jac_heading_speed, jac_heading_steer, jac_speed_drive, output ready);
endinterface
`default_nettype wire

// File: rtl/car_kinematic_euler_step_top.sv
// One forward Euler step of a kinematic car model with its Jacobian entries, Q16.16.
// Depends on ckes_pkg, ckes_if, ckes_cordic and ckes_div.
//
// The block takes one item per clock while out_ch is not stalled and returns one
// result per item, in order. Between acceptance and out_ch lie two CORDIC pipelines of
// CORDIC_ITERATIONS+3 stages, then two chained DIV_BITS+3 (35) stage dividers (tangent,
// then the divide by the wheelbase). A stalled output holds the whole pipeline;
// nothing is dropped. Write the registers only while no item is in flight.
`default_nettype none
module car_kinematic_euler_step_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ckes_pkg::CFG_IW-1:0]   cfg_idx,
	input  logic [31:0]                   cfg_wdata,
	ckes_in_if.sink                       in_ch,
	ckes_out_if.source                    out_ch
);
	import ckes_pkg::*;

	typedef struct packed {
		q16_t x;
		q16_t y;
		q16_t hd;
		q16_t v;
	} carry_t;

	typedef struct packed {
		q16_t hc;
		q16_t hs;
		q16_t hcv;
		q16_t hsv;
	} trig_t;

	typedef struct packed {
		q16_t nx;
		q16_t ny;
		q16_t jxh;
		q16_t jyh;
		q16_t jxs;
		q16_t jys;
	} geo_t;

	logic [30:0] wheelbase_q;
	logic [30:0] step_size_q;
	q16_t        drive_gain_q;
	q16_t        drive_offset_q;
	q16_t        steer_gain_q;
	q16_t        steer_offset_q;
	q16_t        torque_gain_q;
	q16_t        hg2_q;
	q16_t        hg4_q;
	q16_t        h;
	q16_t        l;

	logic   adv;
	logic   valid_s [1:ST_FIN];
	carry_t carry_s [1:ST_FIN-1];

	q16_t drv_s1, str_s1, m1_s2, m2_s2, dev_s3, steer_s3, torque_s4, hsp_s5;
	q16_t nspd_s [6:ST_FIN];

	q16_t hsin, hcos, ssin, scos;
	q16_t c_cs, s_cs, t1_cs;
	q16_t cs2_s [ST_CS:ST_TQ];
	logic signed [63:0] cs2_prod;
	q16_t hc_h, hs_h;
	trig_t trig_hv;
	geo_t geo_s [ST_XY:ST_FIN];

	q16_t tn, tq, htn_s, jhs, r9, jhsv_s, nhd_s;
	q16_t jhs_d [ST_JHS+1:ST_FIN];
	q16_t r9_d [ST_JHS+1:ST_FIN];

	assign h = {1'b0, step_size_q};
	assign l = {1'b0, wheelbase_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheelbase_q <= 31'd65536;
			step_size_q <= 31'd655;
			drive_gain_q <= 32'sd6554;
			drive_offset_q <= '0;
			steer_gain_q <= 32'sd6554;
			steer_offset_q <= '0;
			torque_gain_q <= 32'sd65536;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_WHEELBASE: wheelbase_q <= cfg_wdata[30:0];
				REG_STEP_SIZE: step_size_q <= cfg_wdata[30:0];
				REG_DRIVE_GAIN: drive_gain_q <= cfg_wdata;
				REG_DRIVE_OFFSET: drive_offset_q <= cfg_wdata;
				REG_STEER_GAIN: steer_gain_q <= cfg_wdata;
				REG_STEER_OFFSET: steer_offset_q <= cfg_wdata;
				REG_TORQUE_GAIN: torque_gain_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// products of registers only
	always_ff @(posedge clk) begin
		hg2_q <= fmul(h, drive_gain_q);
		hg4_q <= fmul(h, steer_gain_q);
	end

	assign adv = !valid_s[ST_FIN] || out_ch.ready;
	assign in_ch.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= ST_FIN; k++)
				valid_s[k] <= 1'b0;
		end else if (adv) begin
			valid_s[1] <= in_ch.valid;
			for (int k = 2; k <= ST_FIN; k++)
				valid_s[k] <= valid_s[k-1];
		end
	end

	always_comb cs2_prod = 64'(scos) * 64'(scos);

	always_ff @(posedge clk) begin
		if (adv) begin
			carry_s[1] <= '{in_ch.pos_x, in_ch.pos_y, in_ch.heading, in_ch.speed};
			for (int k = 2; k <= ST_FIN - 1; k++)
				carry_s[k] <= carry_s[k-1];

			drv_s1 <= clamp(in_ch.drive_cmd, DRIVE_LIMIT);
			str_s1 <= clamp(in_ch.steer_cmd, STEER_LIMIT);
			m1_s2 <= fmul(drive_gain_q, drv_s1);
			m2_s2 <= fmul(steer_gain_q, str_s1);
			dev_s3 <= fsub(fadd(m1_s2, drive_offset_q), carry_s[2].v);
			steer_s3 <= fadd(m2_s2, steer_offset_q);
			torque_s4 <= fmul(torque_gain_q, dev_s3);
			hsp_s5 <= fmul(h, torque_s4);
			nspd_s[6] <= fadd(carry_s[5].v, hsp_s5);
			for (int k = 7; k <= ST_FIN; k++)
				nspd_s[k] <= nspd_s[k-1];

			c_cs <= q30_to_q16(hcos);
			s_cs <= q30_to_q16(hsin);
			t1_cs <= fmul(hg4_q, carry_s[ST_CS-1].v);
			cs2_s[ST_CS] <= cs2_prod[61:30];
			for (int k = ST_CS + 1; k <= ST_TQ; k++)
				cs2_s[k] <= cs2_s[k-1];

			hc_h <= fmul(h, c_cs);
			hs_h <= fmul(h, s_cs);
			trig_hv <= '{hc_h, hs_h, fmul(hc_h, carry_s[ST_H].v), fmul(hs_h, carry_s[ST_H].v)};
			geo_s[ST_XY] <= '{
				fadd(carry_s[ST_HV].x, trig_hv.hcv),
				fadd(carry_s[ST_HV].y, trig_hv.hsv),
				sat32(-64'(trig_hv.hsv)),
				trig_hv.hcv,
				trig_hv.hc,
				trig_hv.hs
			};
			for (int k = ST_XY + 1; k <= ST_FIN; k++)
				geo_s[k] <= geo_s[k-1];

			htn_s <= fmul(h, tn);

			jhsv_s <= fmul(jhs, carry_s[ST_JHS].v);
			jhs_d[ST_JHS+1] <= jhs;
			r9_d[ST_JHS+1] <= r9;
			for (int k = ST_JHS + 2; k <= ST_FIN; k++) begin
				jhs_d[k] <= jhs_d[k-1];
				r9_d[k] <= r9_d[k-1];
			end
			nhd_s <= fadd(carry_s[ST_FIN-1].hd, jhsv_s);
		end
	end

	ckes_cordic u_cordic_hd (
		.clk(clk), .en(adv), .angle(carry_s[ST_CIN].hd), .sin_q30(hsin), .cos_q30(hcos)
	);

	ckes_cordic u_cordic_st (
		.clk(clk), .en(adv), .angle(steer_s3), .sin_q30(ssin), .cos_q30(scos)
	);

	ckes_div u_div_tan (
		.clk(clk), .en(adv), .num({{16{ssin[31]}}, ssin, 16'b0}), .den(scos), .quo(tn)
	);

	ckes_div u_div_tq (
		.clk(clk), .en(adv), .num({{16{t1_cs[31]}}, t1_cs, 16'b0}), .den(l), .quo(tq)
	);

	ckes_div u_div_jhs (
		.clk(clk), .en(adv), .num({{16{htn_s[31]}}, htn_s, 16'b0}), .den(l), .quo(jhs)
	);

	ckes_div u_div_r9 (
		.clk(clk), .en(adv), .num({{2{tq[31]}}, tq, 30'b0}), .den(cs2_s[ST_TQ]), .quo(r9)
	);

	assign out_ch.valid = valid_s[ST_FIN];
	assign out_ch.next_x = geo_s[ST_FIN].nx;
	assign out_ch.next_y = geo_s[ST_FIN].ny;
	assign out_ch.next_heading = nhd_s;
	assign out_ch.next_speed = nspd_s[ST_FIN];
	assign out_ch.jac_x_heading = geo_s[ST_FIN].jxh;
	assign out_ch.jac_x_speed = geo_s[ST_FIN].jxs;
	assign out_ch.jac_y_heading = geo_s[ST_FIN].jyh;
	assign out_ch.jac_y_speed = geo_s[ST_FIN].jys;
	assign out_ch.jac_heading_speed = jhs_d[ST_FIN];
	assign out_ch.jac_heading_steer = r9_d[ST_FIN];
	assign out_ch.jac_speed_drive = hg2_q;
endmodule
`default_nettype wire

// File: rtl/ckes_cordic.sv
// Pipelined rotation CORDIC: angle in Q16.16 radians to sin and cos in Q30.
// Depends on ckes_pkg; one stage per iteration, plus phase, seed and output registers.
`default_nettype none
module ckes_cordic (
	input  logic          clk,
	input  logic          en,
	input  ckes_pkg::q16_t angle,
	output ckes_pkg::q16_t sin_q30,
	output ckes_pkg::q16_t cos_q30
);
	import ckes_pkg::*;

	localparam int N = CORDIC_ITERATIONS;

	logic signed [63:0] ph_prod;
	logic signed [31:0] phase_s1;
	logic signed [32:0] p_ext;
	logic signed [32:0] p_fold;
	logic               flip_c;
	logic signed [63:0] z_prod;

	logic signed [CW-1:0] x_s [0:N];
	logic signed [CW-1:0] y_s [0:N];
	logic signed [CW-1:0] z_s [0:N];
	logic                 flip_s [0:N];

	always_comb ph_prod = 64'(angle) * INV_TWO_PI_Q32;

	// fold into [-pi/2, pi/2]
	always_comb begin
		p_ext = 33'(phase_s1);
		p_fold = p_ext;
		flip_c = 1'b0;
		if (p_ext > 33'sh040000000) begin
			p_fold = p_ext - 33'sh080000000;
			flip_c = 1'b1;
		end else if (p_ext < -33'sh040000000) begin
			p_fold = p_ext + 33'sh080000000;
			flip_c = 1'b1;
		end
		z_prod = 64'(p_fold) * TWO_PI_Q29;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			phase_s1 <= ph_prod[47:16];
			x_s[0] <= CW'(GAIN_Q30[GAIN_IDX]);
			y_s[0] <= '0;
			z_s[0] <= CW'($signed(z_prod[63:31]));
			flip_s[0] <= flip_c;
			for (int i = 0; i < N; i++) begin
				flip_s[i+1] <= flip_s[i];
				if (!z_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - CW'(ATAN_Q30[i]);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + CW'(ATAN_Q30[i]);
				end
			end
			sin_q30 <= flip_s[N] ? 32'(-y_s[N]) : 32'(y_s[N]);
			cos_q30 <= flip_s[N] ? 32'(-x_s[N]) : 32'(x_s[N]);
		end
	end
endmodule
`default_nettype wire

// File: rtl/ckes_div.sv
// Pipelined restoring divider, one quotient bit per stage, truncating and saturating.
// Depends on ckes_pkg.
`default_nettype none
module ckes_div (
	input  logic               clk,
	input  logic               en,
	input  logic signed [63:0] num,
	input  ckes_pkg::q16_t      den,
	output ckes_pkg::q16_t      quo
);
	import ckes_pkg::*;

	typedef struct packed {
		logic neg;
		logic npos;
		logic nz;
		logic dz;
	} dflag_t;

	logic [63:0] nmag_s1;
	logic [31:0] dmag_s1;
	dflag_t      fl_s1;

	logic [31:0] rem_s [0:DIV_BITS];
	logic [31:0] lo_s [0:DIV_BITS];
	logic [31:0] q_s [0:DIV_BITS];
	logic [31:0] dmag_s [0:DIV_BITS];
	logic        big_s [0:DIV_BITS];
	dflag_t      fl_s [0:DIV_BITS];

	logic [32:0] r33 [0:DIV_BITS-1];
	logic        ge [0:DIV_BITS-1];
	logic [32:0] qx;

	always_comb begin
		for (int j = 0; j < DIV_BITS; j++) begin
			r33[j] = {rem_s[j], lo_s[j][31]};
			ge[j] = r33[j] >= {1'b0, dmag_s[j]};
		end
		qx = {1'b0, q_s[DIV_BITS]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nmag_s1 <= num[63] ? 64'(-num) : 64'(num);
			dmag_s1 <= den[31] ? 32'(-33'(den)) : 32'(den);
			fl_s1.neg <= num[63] ^ den[31];
			fl_s1.nz <= num != '0;
			fl_s1.npos <= !num[63] && (num != '0);
			fl_s1.dz <= den == '0;

			big_s[0] <= nmag_s1 >= {dmag_s1, 32'b0};
			rem_s[0] <= nmag_s1[63:32];
			lo_s[0] <= nmag_s1[31:0];
			q_s[0] <= '0;
			dmag_s[0] <= dmag_s1;
			fl_s[0] <= fl_s1;

			for (int j = 0; j < DIV_BITS; j++) begin
				rem_s[j+1] <= ge[j] ? 32'(r33[j] - {1'b0, dmag_s[j]}) : r33[j][31:0];
				lo_s[j+1] <= {lo_s[j][30:0], 1'b0};
				q_s[j+1] <= {q_s[j][30:0], ge[j]};
				dmag_s[j+1] <= dmag_s[j];
				big_s[j+1] <= big_s[j];
				fl_s[j+1] <= fl_s[j];
			end

			if (fl_s[DIV_BITS].dz)
				quo <= fl_s[DIV_BITS].npos ? Q16_MAX : (fl_s[DIV_BITS].nz ? Q16_MIN : '0);
			else if (big_s[DIV_BITS])
				quo <= fl_s[DIV_BITS].neg ? Q16_MIN : Q16_MAX;
			else if (fl_s[DIV_BITS].neg)
				quo <= (q_s[DIV_BITS] > 32'h80000000) ? Q16_MIN : 32'(-qx);
			else
				quo <= q_s[DIV_BITS][31] ? Q16_MAX : q_s[DIV_BITS];
		end
	end
endmodule
`default_nettype wire
